### hdl/kff_pkg.sv
`timescale 1ns / 1ps
// kff_pkg: shared types and constants for the streaming KMP failure function block.
// No dependencies; imported by kff_front, kff_back and kmp_failure_function.
package kff_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 8;

    // One queued character transaction
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              last;
    } kff_item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic      valid;
        kff_item_t item;
    } kff_head_t;

endpackage

### hdl/kff_ram.sv
`timescale 1ns / 1ps
// kff_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/kff_front.sv
`timescale 1ns / 1ps
// kff_front: input side; accepts character transactions into a two-entry queue.
// Depends on kff_pkg.
module kff_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_ready,
    input  kff_pkg::kff_item_t in_item,
    output kff_pkg::kff_head_t head,
    input  logic              pop
);
    import kff_pkg::*;

    localparam int QDEPTH = 2;

    kff_item_t  slot_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign char_ready = (count_reg != 2'(QDEPTH));
    assign push       = char_valid && char_ready;

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the payload of each accepted transaction
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("kff_front: pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QDEPTH))
        else $error("kff_front: queue occupancy out of range");
`endif

endmodule

### hdl/kff_back.sv
`timescale 1ns / 1ps
// kff_back: back end; walks the failure table and emits one border per character.
// Depends on kff_pkg and kff_ram.
module kff_back #(
    parameter int MAX_LEN = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kff_pkg::kff_head_t       head,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [kff_pkg::LEN_W-1:0] border_len,
    output logic                     too_long
);
    import kff_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int SW = (AW > LEN_W) ? AW : LEN_W;

    typedef enum logic {ST_IDLE, ST_CMP} state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     border_reg, border_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [BYTE_W-1:0] ch_reg, ch_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic              out_long_reg, out_long_next;

    logic              out_free;
    logic              ram_we, ram_re;
    logic [AW-1:0]     waddr, taddr, faddr;
    logic [BYTE_W-1:0] text_wdata, text_rdata;
    logic [AW-1:0]     fail_wdata, fail_rdata;
    logic              match;
    logic [AW-1:0]     new_j;
    logic [SW-1:0]     new_j_wide;

    // Character and failure tables
    kff_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (text_wdata),
        .re    (ram_re),
        .raddr (taddr),
        .rdata (text_rdata)
    );

    kff_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_fail_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (fail_wdata),
        .re    (ram_re),
        .raddr (faddr),
        .rdata (fail_rdata)
    );

    assign out_free   = !out_valid_reg || result_ready;
    assign match      = (text_rdata == ch_reg);
    assign new_j      = match ? (j_reg + AW'(1)) : '0;
    assign new_j_wide = SW'(new_j);

    // Sequence one character: commit a first or dropped one from idle, else start the walk, fall back, then commit
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        border_next    = border_reg;
        j_next         = j_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_len_next   = out_len_reg;
        out_long_next  = out_long_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        waddr          = pos_reg[AW-1:0];
        taddr          = border_reg;
        faddr          = border_reg - AW'(1);
        text_wdata     = ch_reg;
        fail_wdata     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (pos_reg == PW'(MAX_LEN))
                    begin
                        // Drop the character; string end still clears
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            out_valid_next = 1'b1;
                            out_len_next   = '0;
                            out_long_next  = 1'b1;
                            if (head.item.last)
                            begin
                                pos_next    = '0;
                                border_next = '0;
                            end
                        end
                    end
                    else if (pos_reg == '0)
                    begin
                        // First character of a string has no border
                        if (out_free)
                        begin
                            pop            = 1'b1;
                            ram_we         = 1'b1;
                            text_wdata     = head.item.ch;
                            fail_wdata     = '0;
                            out_valid_next = 1'b1;
                            out_len_next   = '0;
                            out_long_next  = 1'b0;
                            pos_next       = head.item.last ? '0 : PW'(1);
                            border_next    = '0;
                        end
                    end
                    else
                    begin
                        // Read the candidate character and its fallback
                        pop        = 1'b1;
                        ch_next    = head.item.ch;
                        last_next  = head.item.last;
                        ram_re     = 1'b1;
                        j_next     = border_reg;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (match || j_reg == '0)
                begin
                    // Commit the entry and emit the border
                    if (out_free)
                    begin
                        ram_we         = 1'b1;
                        text_wdata     = ch_reg;
                        fail_wdata     = new_j;
                        out_valid_next = 1'b1;
                        out_long_next  = 1'b0;
                        out_len_next   = (new_j_wide > SW'(255)) ? LEN_W'(255)
                                                                 : new_j_wide[LEN_W-1:0];
                        pos_next       = last_reg ? '0 : (pos_reg + PW'(1));
                        border_next    = last_reg ? '0 : new_j;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // Fall back one step through the failure table
                    j_next = fail_rdata;
                    ram_re = 1'b1;
                    taddr  = fail_rdata;
                    faddr  = fail_rdata - AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            border_reg    <= '0;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
            ch_reg        <= '0;
            last_reg      <= 1'b0;
            out_len_reg   <= '0;
            out_long_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            border_reg    <= border_next;
            out_valid_reg <= out_valid_next;
            j_reg         <= j_next;
            ch_reg        <= ch_next;
            last_reg      <= last_next;
            out_len_reg   <= out_len_next;
            out_long_reg  <= out_long_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign border_len   = out_len_reg;
    assign too_long     = out_long_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_LEN))
        else $error("kff_back: position beyond capacity");
    a_border_below_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == '0) ? (border_reg == '0) : (PW'(border_reg) < pos_reg))
        else $error("kff_back: border not below position");
    a_walk_below_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (PW'(j_reg) < pos_reg))
        else $error("kff_back: fallback index reached unwritten entry");
    a_no_emit_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |=> ($stable(out_len_reg) && $stable(out_long_reg)))
        else $error("kff_back: result overwritten while stalled");
`endif

endmodule

### hdl/kmp_failure_function.sv
`timescale 1ns / 1ps
// kmp_failure_function: streaming KMP failure (prefix) function, one border per character.
// First and dropped characters are committed from idle; any other character is read, then walked
// back through the failure RAM until it matches or reaches zero, fallbacks averaging under one per
// character. The back end takes one character at a time; the two-entry front queue buffers more.
// Reset (rst_n, async, active low) clears position, border, queue and output valid;
// the character and failure RAMs are not cleared and may hold entries of earlier strings.
module kmp_failure_function #(
    parameter int MAX_LEN = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_ready,
    input  logic [7:0] char_in,
    input  logic       last_char,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [7:0] border_len,
    output logic       too_long
);
    import kff_pkg::*;

    kff_item_t in_item;
    kff_head_t head;
    logic      pop;

    assign in_item.ch   = char_in;
    assign in_item.last = last_char;

    // Front end: accept and queue characters
    kff_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .in_item    (in_item),
        .head       (head),
        .pop        (pop)
    );

    // Back end: failure-table walk and result register
    kff_back #(.MAX_LEN(MAX_LEN)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .border_len   (border_len),
        .too_long     (too_long)
    );

endmodule

### tb/tb_kmp_failure_function.sv
`timescale 1ns / 1ps
// tb_kmp_failure_function: self-checking bench for the streaming KMP border block.
// Needs hdl/kmp_failure_function.sv with kff_front, kff_back, kff_ram and kff_pkg; predicts every border itself.
module tb_kmp_failure_function;

    localparam int STR_CAP     = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 200;
    localparam int TAIL_CYCLES = 12;

    typedef struct packed {
        logic [7:0] border_len;
        logic       too_long;
    } border_result_t;

    // Border predictor plus the queue of borders still owed by the block
    class border_scoreboard;
        logic [7:0]     text_mem [STR_CAP];
        int             fail_mem [STR_CAP];
        int             str_pos;
        int             cur_border;
        border_result_t expected_q [$];
        int             errors;

        function new();
            str_pos    = 0;
            cur_border = 0;
            errors     = 0;
            foreach (text_mem[k])
            begin
                text_mem[k] = '0;
                fail_mem[k] = 0;
            end
        endfunction

        // Advance the prefix function by one accepted character
        function void note_char(logic [7:0] ch, logic last);
            border_result_t exp_r;
            int             j;
            int             nj;
            exp_r = '0;
            if (str_pos >= STR_CAP)
            begin
                exp_r.too_long = 1'b1;
            end
            else if (str_pos == 0)
            begin
                text_mem[0] = ch;
                fail_mem[0] = 0;
                cur_border  = 0;
                str_pos     = 1;
            end
            else
            begin
                j = cur_border;
                // fall back until the next pattern character matches
                while (j > 0 && j < str_pos && text_mem[j] != ch)
                begin
                    nj = fail_mem[j - 1];
                    j  = (nj < j) ? nj : 0;
                end
                if (j < str_pos && text_mem[j] == ch)
                    j++;
                fail_mem[str_pos] = j;
                text_mem[str_pos] = ch;
                cur_border        = j;
                str_pos++;
                exp_r.border_len = (j > 255) ? 8'd255 : 8'(j);
            end
            if (last)
            begin
                str_pos    = 0;
                cur_border = 0;
            end
            expected_q.push_back(exp_r);
        endfunction

        // Compare one result transaction against the oldest expectation
        function void check_result(logic [7:0] blen, logic tl);
            border_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: border_len=%0d too_long=%0b", $time, blen, tl);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (blen !== exp_r.border_len)
            begin
                $display("%0t: border_len mismatch: expected %0d, actual %0d",
                         $time, exp_r.border_len, blen);
                errors++;
            end
            if (tl !== exp_r.too_long)
            begin
                $display("%0t: too_long mismatch: expected %0b, actual %0b",
                         $time, exp_r.too_long, tl);
                errors++;
            end
        endfunction
    endclass

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       char_valid   = 1'b0;
    logic       char_ready;
    logic [7:0] char_in      = 8'h00;
    logic       last_char    = 1'b0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [7:0] border_len;
    logic       too_long;

    border_scoreboard sb;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               phase_items;

    kmp_failure_function #(
        .MAX_LEN(STR_CAP)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_in     (char_in),
        .last_char   (last_char),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .border_len  (border_len),
        .too_long    (too_long)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Check result transactions and randomize backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                sb.check_result(border_len, too_long);
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort a hung run
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one character and hold it until the block takes the transaction
    task automatic send_char(input logic [7:0] ch, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        char_valid <= 1'b1;
        char_in    <= ch;
        last_char  <= last;
        do @(posedge clk); while (!char_ready);
        sb.note_char(ch, last);
        phase_items++;
    endtask

    // Send a string drawn from a small alphabet around a repeating pattern
    task automatic send_pattern_string(input int len, input int alpha_n, input int period,
                                       input logic terminate);
        logic [7:0] alphabet [3];
        logic [7:0] pat [4];
        logic [7:0] ch;
        foreach (alphabet[k])
            alphabet[k] = 8'($urandom_range(255));
        foreach (pat[k])
            pat[k] = alphabet[$urandom_range(alpha_n - 1)];
        for (int i = 0; i < len; i++)
        begin
            ch = pat[i % period];
            if ($urandom_range(99) < 15)
                ch = alphabet[$urandom_range(alpha_n - 1)];
            send_char(ch, terminate && (i == len - 1));
        end
    endtask

    // Hold off the sender until every owed result has arrived
    task automatic wait_drained();
        char_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // Send short strings: mostly patterned, some full-range bytes
    task automatic run_short_strings();
        int len;
        while (phase_items < PHASE_ITEMS)
        begin
            len = $urandom_range(1, 24);
            if ($urandom_range(99) < 30)
            begin
                for (int i = 0; i < len; i++)
                    send_char(8'($urandom_range(255)), i == len - 1);
            end
            else
            begin
                send_pattern_string(len, $urandom_range(2, 3), $urandom_range(1, 4), 1'b1);
            end
        end
    endtask

    initial
    begin
        logic [7:0] run_ch;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single-character string of a zero byte
        send_char(8'h00, 1'b1);
        // all-ones bytes, border grows each step
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b1);
        // "abacabab": border falls back on the final character
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char("a", 1'b0);
        send_char("c", 1'b0);
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char("a", 1'b0);
        send_char("b", 1'b1);
        // alternate the byte extremes
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        // "aabaaab": border falls back one level on the sixth character
        send_char("a", 1'b0);
        send_char("a", 1'b0);
        send_char("b", 1'b0);
        send_char("a", 1'b0);
        send_char("a", 1'b0);
        send_char("a", 1'b0);
        send_char("b", 1'b1);
        wait_drained();

        // Phase 0, no idling: one full-capacity run of one byte, border up to 255
        phase_items = 0;
        run_ch = 8'($urandom_range(255));
        for (int i = 0; i < STR_CAP; i++)
            send_char(run_ch, i == STR_CAP - 1);
        run_short_strings();
        wait_drained();

        // Phase 1, sender idles
        phase_items   = 0;
        send_idle_pct = 46;
        run_short_strings();
        wait_drained();

        // Phase 2, receiver stalls
        phase_items    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 46;
        run_short_strings();
        wait_drained();

        // Phase 3, both idle: fill the store, then drop two bytes, the last one ending it
        phase_items    = 0;
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        send_pattern_string(STR_CAP, 2, 3, 1'b0);
        send_char(8'($urandom_range(255)), 1'b0);
        send_char(8'($urandom_range(255)), 1'b1);
        run_short_strings();
        char_valid <= 1'b0;

        // Drain and let any stray result show up
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
